// File: sv/csvs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_pkg
// Shared types, constants and helpers for the CSV line field splitter.
// ----------------------------------------------------------------------------
package csvs_pkg;

  // Default sizes
  localparam int FieldLenDef      = 32;
  localparam int MaxFieldCountDef = 16;

  // Characters with a meaning to the parser
  localparam logic [7:0] CharQuote = 8'h22;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharCr    = 8'h0D;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       line_last;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic [3:0] field_number;
    logic       field_end;
    logic       line_end;
    logic [4:0] field_total;
    logic       run_last;
  } out_item_t;

  // Emission sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StPush,
    StOne
  } state_e;

  // C-locale whitespace: space, tab, newline, vertical tab, form feed, CR
  function automatic logic is_c_space(input logic [7:0] b);
    return (b == CharSpace) || ((b >= CharTab) && (b <= CharCr));
  endfunction

endpackage
`default_nettype wire

// File: sv/csvs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csvs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module csvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: sv/csv_line_field_splitter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// Splits a CSV line, one byte per item, into whitespace-trimmed fields.
// ----------------------------------------------------------------------------
// One item is taken at a time. The accepting cycle parses the byte, writes it
// into the field buffer RAM and updates the line state. An item that closes
// no field leaves the sequencer idle for the next item. A closed field with
// kept characters then has a RAM read (StRead) and emits one result per
// kept character (StPush); an empty field or a bare line end gives one
// result (StOne); a separator on a line's last byte adds one more. Output
// stall holds emission. The field buffer RAM (one write and one read port) sets the pace.
module csv_line_field_splitter
  import csvs_pkg::*;
#(
  parameter int FIELD_LEN       = FieldLenDef,
  parameter int MAX_FIELD_COUNT = MaxFieldCountDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o
);

  localparam int BufDepth = FIELD_LEN - 1;
  localparam int AW       = (BufDepth > 1) ? $clog2(BufDepth) : 1;
  localparam int PW       = $clog2(FIELD_LEN);
  localparam int FIW      = $clog2(MAX_FIELD_COUNT + 1);
  localparam int XW       = (FIW + 1 > 5) ? FIW + 1 : 5;

  localparam logic [PW-1:0]  LenLimit = PW'(BufDepth);
  localparam logic [FIW-1:0] MaxIdx   = FIW'(MAX_FIELD_COUNT);
  localparam logic [4:0]     MaxTot   = 5'(MAX_FIELD_COUNT);

  // Line state
  logic           quoting_q, quoting_d;
  logic           qpend_q, qpend_d;
  logic [FIW-1:0] fidx_q, fidx_d;
  logic [PW-1:0]  len_q, len_d;
  logic           seen_q, seen_d;
  logic [AW-1:0]  first_q, first_d;
  logic [AW-1:0]  last_q, last_d;

  // Pending emission job
  logic           a_pend_q, a_pend_d;
  logic           a_seen_q, a_seen_d;
  logic [AW-1:0]  a_first_q, a_first_d;
  logic [AW-1:0]  a_last_q, a_last_d;
  logic           a_lend_q, a_lend_d;
  logic [FIW-1:0] a_fidx_q, a_fidx_d;
  logic           b_pend_q, b_pend_d;
  logic           b_bare_q, b_bare_d;
  logic [FIW-1:0] b_fidx_q, b_fidx_d;

  state_e         state_q, state_d;
  logic [AW-1:0]  rd_ptr_q, rd_ptr_d;

  logic           out_valid_q;
  out_item_t      out_q, out_n;
  logic           load;
  logic           slot_free;

  logic           accept;
  logic           st_en, wr_en, sep_close, handled, qeff;
  logic [7:0]     st_byte;
  logic [AW-1:0]  wr_addr;
  logic           job_a, job_b, job_bare;
  logic [FIW-1:0] fidx_next;

  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;

  logic [XW-1:0]  ix_a, tot_a, ix_b, tot_b;

  assign accept    = in_valid_i && (state_q == StIdle);
  assign in_stall_o = (state_q != StIdle);
  assign slot_free = !out_valid_q || !out_stall_i;
  assign wr_addr   = AW'(len_q);
  assign fidx_next = fidx_q + FIW'(1);

  assign ix_a  = XW'(a_fidx_q);
  assign tot_a = ix_a + XW'(1);
  assign ix_b  = XW'(b_fidx_q);
  assign tot_b = ix_b + XW'(1);

  // Parse one byte: quoting, separators, buffer store and job setup
  always_comb begin
    quoting_d = quoting_q;
    qpend_d   = qpend_q;
    fidx_d    = fidx_q;
    len_d     = len_q;
    seen_d    = seen_q;
    first_d   = first_q;
    last_d    = last_q;
    st_en     = 1'b0;
    st_byte   = in_item_i.in_byte;
    sep_close = 1'b0;
    handled   = 1'b0;
    qeff      = quoting_q;
    job_a     = 1'b0;
    job_b     = 1'b0;
    job_bare  = 1'b0;

    if (fidx_q < MaxIdx) begin
      // A pending quote is either doubled or closes the quotes
      if (qpend_q) begin
        qpend_d = 1'b0;
        if (in_item_i.in_byte == CharQuote) begin
          st_en   = 1'b1;
          st_byte = CharQuote;
          handled = 1'b1;
        end else begin
          qeff = 1'b0;
        end
      end
      quoting_d = qeff;
      if (!handled) begin
        if (in_item_i.in_byte == CharQuote) begin
          if (qeff) begin
            qpend_d = 1'b1;
          end else begin
            quoting_d = 1'b1;
          end
        end else if (((in_item_i.in_byte == CharComma) ||
                      (in_item_i.in_byte == CharTab)) && !qeff) begin
          sep_close = 1'b1;
        end else begin
          st_en = 1'b1;
        end
      end
    end

    // Store into the buffer while there is room
    wr_en = st_en && (len_q < LenLimit);
    if (wr_en) begin
      if (!is_c_space(st_byte)) begin
        if (!seen_q) begin
          first_d = wr_addr;
        end
        seen_d = 1'b1;
        last_d = wr_addr;
      end
      len_d = len_q + PW'(1);
    end

    // Results this byte causes
    if (sep_close) begin
      job_a  = 1'b1;
      fidx_d = fidx_next;
      len_d  = '0;
      seen_d = 1'b0;
      first_d = '0;
      last_d  = '0;
      if (in_item_i.line_last) begin
        job_b    = 1'b1;
        job_bare = !(fidx_next < MaxIdx);
      end
    end else if (in_item_i.line_last) begin
      if (fidx_q < MaxIdx) begin
        job_a = 1'b1;
      end else begin
        job_b    = 1'b1;
        job_bare = 1'b1;
      end
    end

    // Line end returns the line state to reset
    if (in_item_i.line_last) begin
      quoting_d = 1'b0;
      qpend_d   = 1'b0;
      fidx_d    = '0;
      len_d     = '0;
      seen_d    = 1'b0;
      first_d   = '0;
      last_d    = '0;
    end
  end

  // Emission sequencer
  always_comb begin
    state_d   = state_q;
    rd_ptr_d  = rd_ptr_q;
    a_pend_d  = a_pend_q;
    a_seen_d  = a_seen_q;
    a_first_d = a_first_q;
    a_last_d  = a_last_q;
    a_lend_d  = a_lend_q;
    a_fidx_d  = a_fidx_q;
    b_pend_d  = b_pend_q;
    b_bare_d  = b_bare_q;
    b_fidx_d  = b_fidx_q;
    ram_re    = 1'b0;
    ram_raddr = rd_ptr_q;
    load      = 1'b0;
    out_n     = '0;

    case (state_q)
      StIdle: begin
        if (accept) begin
          a_pend_d  = job_a;
          a_seen_d  = seen_d;
          a_first_d = first_d;
          a_last_d  = last_d;
          a_lend_d  = in_item_i.line_last && !sep_close;
          a_fidx_d  = fidx_q;
          b_pend_d  = job_b;
          b_bare_d  = job_bare;
          b_fidx_d  = fidx_next;
          // the job captures post-store positions, taken before line clear
          if (job_a) begin
            a_seen_d  = seen_q || (wr_en && !is_c_space(st_byte));
            a_first_d = seen_q ? first_q : wr_addr;
            a_last_d  = (wr_en && !is_c_space(st_byte)) ? wr_addr : last_q;
          end
          if (job_a && a_seen_d) begin
            state_d = StRead;
          end else if (job_a || job_b) begin
            state_d = StOne;
          end
        end
      end

      StRead: begin
        ram_re    = 1'b1;
        ram_raddr = a_first_q;
        rd_ptr_d  = a_first_q;
        state_d   = StPush;
      end

      StPush: begin
        if (slot_free) begin
          load               = 1'b1;
          out_n.out_byte     = ram_rdata;
          out_n.has_byte     = 1'b1;
          out_n.field_number = ix_a[3:0];
          if (rd_ptr_q == a_last_q) begin
            out_n.field_end   = 1'b1;
            out_n.line_end    = a_lend_q;
            out_n.field_total = a_lend_q ? tot_a[4:0] : 5'd0;
            out_n.run_last    = !b_pend_q;
            a_pend_d          = 1'b0;
            state_d           = b_pend_q ? StOne : StIdle;
          end else begin
            rd_ptr_d  = rd_ptr_q + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = rd_ptr_q + AW'(1);
          end
        end
      end

      StOne: begin
        if (slot_free) begin
          load = 1'b1;
          if (a_pend_q) begin
            // empty field
            out_n.field_number = ix_a[3:0];
            out_n.field_end    = 1'b1;
            out_n.line_end     = a_lend_q;
            out_n.field_total  = a_lend_q ? tot_a[4:0] : 5'd0;
            out_n.run_last     = !b_pend_q;
            a_pend_d           = 1'b0;
            state_d            = b_pend_q ? StOne : StIdle;
          end else begin
            out_n.line_end = 1'b1;
            out_n.run_last = 1'b1;
            if (b_bare_q) begin
              out_n.field_total = MaxTot;
            end else begin
              out_n.field_number = ix_b[3:0];
              out_n.field_end    = 1'b1;
              out_n.field_total  = tot_b[4:0];
            end
            b_pend_d = 1'b0;
            state_d  = StIdle;
          end
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Field buffer
  csvs_ram #(
    .WIDTH (8),
    .DEPTH (BufDepth)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (accept && wr_en),
    .waddr_i (wr_addr),
    .wdata_i (st_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control and line state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rd_ptr_q  <= '0;
      quoting_q <= 1'b0;
      qpend_q   <= 1'b0;
      fidx_q    <= '0;
      len_q     <= '0;
      seen_q    <= 1'b0;
      first_q   <= '0;
      last_q    <= '0;
      a_pend_q  <= 1'b0;
      a_seen_q  <= 1'b0;
      a_first_q <= '0;
      a_last_q  <= '0;
      a_lend_q  <= 1'b0;
      a_fidx_q  <= '0;
      b_pend_q  <= 1'b0;
      b_bare_q  <= 1'b0;
      b_fidx_q  <= '0;
    end else begin
      state_q   <= state_d;
      rd_ptr_q  <= rd_ptr_d;
      a_pend_q  <= a_pend_d;
      a_seen_q  <= a_seen_d;
      a_first_q <= a_first_d;
      a_last_q  <= a_last_d;
      a_lend_q  <= a_lend_d;
      a_fidx_q  <= a_fidx_d;
      b_pend_q  <= b_pend_d;
      b_bare_q  <= b_bare_d;
      b_fidx_q  <= b_fidx_d;
      if (accept) begin
        quoting_q <= quoting_d;
        qpend_q   <= qpend_d;
        fidx_q    <= fidx_d;
        len_q     <= len_d;
        seen_q    <= seen_d;
        first_q   <= first_d;
        last_q    <= last_d;
      end
    end
  end

  // Output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // read pointer stays inside the kept span of the field
  a_ptr_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StPush) |-> ((rd_ptr_q >= a_first_q) && (rd_ptr_q <= a_last_q)))
    else $error("read pointer outside field span");

  // field index never passes the field limit
  a_fidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fidx_q <= MaxIdx)
    else $error("field index beyond limit");

  // a line end clears the line state
  a_line_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_item_i.line_last) |=> ((fidx_q == '0) && !quoting_q && !qpend_q &&
                                         (len_q == '0) && !seen_q))
    else $error("line state not cleared at line end");

  // the last result of an item returns the sequencer to idle
  a_run_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && out_n.run_last) |=> (state_q == StIdle))
    else $error("sequencer busy after last result");

  // buffer fill never exceeds its depth
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenLimit)
    else $error("buffer fill beyond depth");
`endif

endmodule
`default_nettype wire

// File: dv/tb_csv_line_field_splitter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_csv_line_field_splitter
// Self-checking bench for the CSV line field splitter. A short table of
// directed lines covers quoting, doubled quotes, separators and trimming.
// Random lines follow, built mostly from well-formed fields. Every result
// item is checked against a predicted stream of trimmed field characters.
// ----------------------------------------------------------------------------
module tb_csv_line_field_splitter
  import csvs_pkg::*;
();

  localparam int FieldLen    = FieldLenDef;
  localparam int MaxFields   = MaxFieldCountDef;
  // random items; with the directed rows about 280 in all
  localparam int RandItems   = 256;
  localparam int HoldCycles  = 300;
  localparam int WatchLimit  = 5000;
  localparam int DrainCycles = 64;

  // One directed row; res is only meaningful when typed is set
  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       typed;
    out_item_t  res;
  } stim_row_t;

  localparam int NumRows = 24;
  localparam stim_row_t DirRows [NumRows] = '{
    // single-byte lines straight after reset, and the byte extremes
    '{8'h61, 1'b1, 1'b1, '{8'h61, 1'b1, 4'd0, 1'b1, 1'b1, 5'd1, 1'b1}},
    '{8'hFF, 1'b1, 1'b1, '{8'hFF, 1'b1, 4'd0, 1'b1, 1'b1, 5'd1, 1'b1}},
    '{8'h01, 1'b1, 1'b1, '{8'h01, 1'b1, 4'd0, 1'b1, 1'b1, 5'd1, 1'b1}},
    // whitespace only: one empty-field result
    '{8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, 4'd0, 1'b1, 1'b1, 5'd1, 1'b1}},
    // quote pending at line end closes the quotes, nothing stored
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h22, 1'b1, 1'b1, '{8'h00, 1'b0, 4'd0, 1'b1, 1'b1, 5'd1, 1'b1}},
    // separator as the last byte
    '{8'h2C, 1'b1, 1'b0, '0},
    // doubled quote, separators inside quotes, then pending quote + space
    '{8'h20, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h41, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h2C, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h20, 1'b0, 1'b0, '0},
    '{8'h09, 1'b0, 1'b0, '0},
    // inner whitespace kept, pending quote then comma on the last byte
    '{8'h0D, 1'b0, 1'b0, '0},
    '{8'h42, 1'b0, 1'b0, '0},
    '{8'h0A, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b0, '0},
    '{8'h22, 1'b0, 1'b0, '0},
    '{8'h2C, 1'b1, 1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  csv_line_field_splitter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #5 clk = ~clk;

  // Bench control
  int        send_idle   = 19;
  int        recv_idle   = 72;
  logic      hold_req    = 1'b0;
  int        errors      = 0;
  int        sent_items  = 0;
  int        idle_cycles = 0;
  out_item_t field_chars_q [$];
  out_item_t step_chars [$];
  in_item_t  line_q [$];

  // Predicted parser state
  logic       quoting;
  logic       quote_wait;
  logic [4:0] fidx;
  int         slen;
  logic       seen;
  int         first_pos;
  int         last_pos;
  logic [7:0] fbuf [FieldLen];

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void clear_field();
    slen      = 0;
    seen      = 1'b0;
    first_pos = 0;
    last_pos  = 0;
  endfunction

  function automatic void clear_line();
    quoting    = 1'b0;
    quote_wait = 1'b0;
    fidx       = '0;
    clear_field();
  endfunction

  function automatic void keep_char(logic [7:0] c);
    if (slen < FieldLen - 1) begin
      fbuf[slen] = c;
      if (!is_blank(c)) begin
        if (!seen) first_pos = slen;
        seen     = 1'b1;
        last_pos = slen;
      end
      slen++;
    end
  endfunction

  function automatic void add_char(logic [7:0] c, logic has, logic [3:0] fnum,
                                   logic fend, logic lend, logic [4:0] total);
    out_item_t r;
    r.out_byte     = c;
    r.has_byte     = has;
    r.field_number = fnum;
    r.field_end    = fend;
    r.line_end     = lend;
    r.field_total  = lend ? total : 5'd0;
    r.run_last     = 1'b0;
    step_chars.push_back(r);
  endfunction

  // Emit the trimmed field, or one empty-field marker
  function automatic void emit_field(logic lend);
    int i;
    if (seen) begin
      for (i = first_pos; i <= last_pos; i++)
        add_char(fbuf[i], 1'b1, fidx[3:0], i == last_pos, lend && i == last_pos,
                 fidx + 5'd1);
    end else begin
      add_char(8'h00, 1'b0, fidx[3:0], 1'b1, lend, fidx + 5'd1);
    end
    fidx++;
    clear_field();
  endfunction

  // Advance the predicted state by one byte; results land in step_chars
  function automatic void split_byte(in_item_t it);
    logic      done;
    out_item_t r;
    step_chars.delete();
    if (fidx < MaxFields) begin
      done = 1'b0;
      if (quote_wait) begin
        quote_wait = 1'b0;
        if (it.in_byte == CharQuote) begin
          keep_char(CharQuote);
          done = 1'b1;
        end else begin
          quoting = 1'b0;
        end
      end
      if (!done) begin
        if (it.in_byte == CharQuote) begin
          if (quoting) quote_wait = 1'b1;
          else quoting = 1'b1;
        end else if ((it.in_byte == CharComma || it.in_byte == CharTab) && !quoting) begin
          emit_field(1'b0);
        end else begin
          keep_char(it.in_byte);
        end
      end
    end
    if (it.line_last) begin
      if (fidx < MaxFields) emit_field(1'b1);
      else add_char(8'h00, 1'b0, 4'd0, 1'b0, 1'b1, 5'(MaxFields));
      clear_line();
    end
    if (step_chars.size() > 0) begin
      r = step_chars.pop_back();
      r.run_last = 1'b1;
      step_chars.push_back(r);
    end
  endfunction

  // Offer one item at the falling edge, hold it until taken
  task automatic send_item(in_item_t it, logic typed, out_item_t res);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    split_byte(it);
    sent_items++;
    if (typed) field_chars_q.push_back(res);
    else foreach (step_chars[k]) field_chars_q.push_back(step_chars[k]);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    int unsigned w;
    r = $urandom_range(99);
    if (r < 45) return 8'($urandom_range(8'h61, 8'h7A));
    if (r < 60) begin
      w = $urandom_range(5);
      return (w == 5) ? CharSpace : 8'(9 + w);
    end
    if (r < 67) return CharQuote;
    if (r < 72) return CharComma;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic void push_byte(logic [7:0] c);
    in_item_t it;
    it.in_byte   = c;
    it.line_last = 1'b0;
    line_q.push_back(it);
  endfunction

  // Build one line: mostly well-formed fields, some broken, some noise
  function automatic void gen_line();
    int        nf;
    int        len;
    int        k;
    int        j;
    logic      quoted;
    logic [7:0] c;
    in_item_t  it;
    line_q.delete();
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 12);
      for (j = 0; j < len; j++) push_byte(8'($urandom_range(1, 255)));
    end else begin
      nf = ($urandom_range(4) == 0) ? $urandom_range(14, 19) : $urandom_range(1, 5);
      for (k = 0; k < nf; k++) begin
        if (k > 0) push_byte($urandom_range(1) ? CharComma : CharTab);
        if (nf <= 5 && $urandom_range(9) < 2) len = $urandom_range(25, 40);
        else len = $urandom_range(0, 6);
        quoted = ($urandom_range(3) == 0);
        if (quoted) push_byte(CharQuote);
        for (j = 0; j < len; j++) begin
          c = pick_char();
          if (quoted && c == CharQuote) begin
            push_byte(CharQuote);
            if ($urandom_range(4) != 0) push_byte(CharQuote);
          end else if (!quoted && (c == CharQuote || c == CharComma || c == CharTab)
                       && $urandom_range(9) != 0) begin
            push_byte(8'h2D);
          end else begin
            push_byte(c);
          end
        end
        if (quoted && $urandom_range(9) != 0) push_byte(CharQuote);
      end
    end
    if (line_q.size() == 0) push_byte(8'h78);
    it = line_q.pop_back();
    it.line_last = 1'b1;
    line_q.push_back(it);
  endfunction

  // Receiver: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        out_stall = 1'b1;
        repeat (HoldCycles) @(negedge clk);
      end
      out_stall = ($urandom_range(99) < recv_idle);
    end
  end

  // Check each result item against the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (field_chars_q.size() == 0) begin
        $display("%0t: unexpected result byte %h has %b field %0d fend %b lend %b total %0d last %b",
                 $time, out_item.out_byte, out_item.has_byte, out_item.field_number,
                 out_item.field_end, out_item.line_end, out_item.field_total,
                 out_item.run_last);
        errors++;
      end else begin
        want = field_chars_q.pop_front();
        if (out_item !== want) begin
          $display("%0t: mismatch, expected byte %h has %b field %0d fend %b lend %b total %0d last %b",
                   $time, want.out_byte, want.has_byte, want.field_number,
                   want.field_end, want.line_end, want.field_total, want.run_last);
          $display("%0t:           actual byte %h has %b field %0d fend %b lend %b total %0d last %b",
                   $time, out_item.out_byte, out_item.has_byte, out_item.field_number,
                   out_item.field_end, out_item.line_end, out_item.field_total,
                   out_item.run_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin
    int       r;
    int       base;
    int       phase;
    int       prev_phase;
    in_item_t it;
    clear_line();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < NumRows; r++) begin
      it.in_byte   = DirRows[r].b;
      it.line_last = DirRows[r].last;
      send_item(it, DirRows[r].typed, DirRows[r].res);
    end

    // random lines; the receiver holds off early on so the block backs up
    base       = sent_items;
    prev_phase = 0;
    hold_req   = 1'b1;
    while (sent_items - base < RandItems) begin
      phase = (sent_items - base < RandItems / 3) ? 0 :
              (sent_items - base < 2 * RandItems / 3) ? 1 : 2;
      if (phase != prev_phase) begin
        // sender pauses until the block has drained
        in_valid = 1'b0;
        @(negedge clk);
        while (field_chars_q.size() != 0) @(negedge clk);
        send_idle  = (phase == 1) ? 72 : 0;
        recv_idle  = (phase == 1) ? 19 : 0;
        prev_phase = phase;
      end
      gen_line();
      // cut the final line short so the run keeps to its item budget
      while (line_q.size() > 1 && line_q.size() > RandItems - (sent_items - base))
        void'(line_q.pop_back());
      it = line_q.pop_back();
      it.line_last = 1'b1;
      line_q.push_back(it);
      foreach (line_q[j]) send_item(line_q[j], 1'b0, '0);
    end

    in_valid = 1'b0;
    @(negedge clk);
    while (field_chars_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
